// ===== rtl/note_to_frequency_tuned_top_defines.svh =====
// Assertion macros for the tuned note-to-frequency block.
`ifndef NOTE_TO_FREQUENCY_TUNED_TOP_DEFINES_SVH
`define NOTE_TO_FREQUENCY_TUNED_TOP_DEFINES_SVH

// checked outside reset only
`define NTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ntf_pkg.sv =====
// Constants and elaboration-time table functions for the tuned note-to-frequency block.
package ntf_pkg;

  localparam int NST        = 11;
  localparam int OCT_UNITS  = 19200;
  localparam int SEMI_UNITS = 1600;
  localparam int HALF_OCT   = 9600;
  localparam int OFF_W      = 13;
  localparam int D_W        = 19;
  localparam int DIFF_W     = 28;
  localparam int Q_W        = 34;
  localparam int RECIP_SH   = 40;
  localparam int RECIP_W    = 34;

  // ceil(2^40 / 75): exact floor(x/75) for x below 2^33.8
  localparam logic [RECIP_W-1:0] RECIP75 = 34'd14660155038;

  localparam logic [2:0] REG_REF_FREQ = 3'd0;
  localparam logic [2:0] REG_REF_NOTE = 3'd1;
  localparam logic [2:0] REG_OFFS0    = 3'd2;
  localparam logic [2:0] REG_OFFS1    = 3'd3;
  localparam logic [2:0] REG_OFFS2    = 3'd4;

  localparam logic [23:0] REF_FREQ_RST = 24'd112640;
  localparam logic [6:0]  REF_NOTE_RST = 7'd69;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = x;
    res = '0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Q2.30 entry i of the exp2 table for a table of 2^tb intervals
  function automatic logic [31:0] exp_entry(input int tb, input int i);
    logic [63:0] r [0:10];
    logic [63:0] acc;
    for (int k = 0; k <= 10; k++) begin
      r[k] = '0;
    end
    r[0] = 64'd2 << 30;
    for (int k = 1; k <= tb; k++) begin
      r[k] = isqrt64(r[k-1] << 30);
    end
    acc = 64'd1 << 30;
    for (int j = 0; j <= tb; j++) begin
      if (((i >> j) & 1) != 0) begin
        acc = (acc * r[tb-j] + (64'd1 << 29)) >> 30;
      end
    end
    return acc[31:0];
  endfunction

endpackage

// ===== rtl/note_to_frequency_tuned_top.sv =====
// Tuned MIDI note to frequency converter, top level.
// Usage:
//   in_*  : one item per MIDI note; in_tdata[6:0] is the note number.
//   out_* : one item per input; out_tdata is the frequency in 1/256 Hz,
//           out_tuser is set when the value saturated at 0xFFFFFFFF.
//   cfg_* : APB register port, 64-bit data, registers at 8-byte steps:
//           0 ref_frequency, 1 ref_note, 2..4 packed 13-bit offsets in 1/16 cent.
//           Write registers only while no item is in flight.
// Timing:
//   Eleven register stages from input to output.
//   One item per cycle while out_tready is high; the stage count is set
//   by the two reciprocal divisions by 19200 and the split interpolation divide.
// Reset (rst_n low, synchronous): stage valids clear, registers return
// to 440 Hz at note 69 with zero offsets.
// Stall: a stage holds while its successor is full and held; bubbles are
// squeezed out, so input is taken whenever any stage is free.
module note_to_frequency_tuned_top #(
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [6:0] note_number, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] frequency
  output logic        out_tuser,    // [0] saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ntf_pkg::*;

  localparam int B     = EXP_TABLE_BITS;
  localparam int EXP_N = 2 ** B;
  localparam int T_W   = 15 + B;
  localparam int TH_W  = T_W - 8;
  localparam int P5_W  = TH_W + RECIP_W;

  // ---------------- configuration ----------------
  logic [23:0] ref_freq_r;
  logic [6:0]  ref_note_r;
  logic [51:0] offs0_r, offs1_r, offs2_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r <= REF_FREQ_RST;
      ref_note_r <= REF_NOTE_RST;
      offs0_r    <= '0;
      offs1_r    <= '0;
      offs2_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        REG_REF_FREQ: ref_freq_r <= cfg_pwdata[23:0];
        REG_REF_NOTE: ref_note_r <= cfg_pwdata[6:0];
        REG_OFFS0:    offs0_r    <= cfg_pwdata[51:0];
        REG_OFFS1:    offs1_r    <= cfg_pwdata[51:0];
        REG_OFFS2:    offs2_r    <= cfg_pwdata[51:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_REF_FREQ: cfg_prdata = {40'd0, ref_freq_r};
      REG_REF_NOTE: cfg_prdata = {57'd0, ref_note_r};
      REG_OFFS0:    cfg_prdata = {12'd0, offs0_r};
      REG_OFFS1:    cfg_prdata = {12'd0, offs1_r};
      REG_OFFS2:    cfg_prdata = {12'd0, offs2_r};
      default:      cfg_prdata = '0;
    endcase
  end

  logic [155:0]            offs_flat;
  logic signed [OFF_W-1:0] offs [16];

  assign offs_flat = {offs2_r, offs1_r, offs0_r};

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      offs[k] = offs_flat[k*OFF_W +: OFF_W];
    end
    for (int k = 12; k < 16; k++) begin
      offs[k] = '0;
    end
  end

  // ---------------- exp2 table ----------------
  logic [31:0] exp_tab [EXP_N+1];

  for (genvar gi = 0; gi <= EXP_N; gi++) begin : g_tab
    assign exp_tab[gi] = exp_entry(B, gi);
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- S1: pitch class, note distance ----------------
  logic [6:0]        note;
  logic [12:0]       n43;
  logic [3:0]        quo12;
  logic [6:0]        pc_full;
  logic [3:0]        s1_pc_r;
  logic signed [7:0] s1_dn_r, s1_dn_nxt;

  assign note      = in_tdata[6:0];
  assign n43       = 13'(note) * 13'd43;
  assign quo12     = n43[12:9];
  assign pc_full   = note - 7'(quo12) * 7'd12;
  assign s1_dn_nxt = $signed({1'b0, note}) - $signed({1'b0, ref_note_r});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pc_r <= pc_full[3:0];
      s1_dn_r <= s1_dn_nxt;
    end
  end

  // ---------------- S2: distance in 1/16 cent ----------------
  logic signed [D_W-1:0] s2_d_r, s2_d_nxt;

  assign s2_d_nxt = D_W'(s1_dn_r) * D_W'(SEMI_UNITS) + D_W'(offs[s1_pc_r]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_d_r <= s2_d_nxt;
    end
  end

  // ---------------- S3: octave = floor(d / 19200) ----------------
  logic signed [D_W-1:0] d_sh;
  logic [10:0]           oct_x;
  logic [44:0]           oct_prod;
  logic signed [4:0]     s3_oct_r, s3_oct_nxt;
  logic signed [D_W-1:0] s3_d_r;

  assign d_sh       = s2_d_r >>> 8;
  assign oct_x      = d_sh[10:0] + 11'd825;
  assign oct_prod   = 45'(oct_x) * 45'(RECIP75);
  assign s3_oct_nxt = $signed(oct_prod[44:40] - 5'd11);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_oct_r <= s3_oct_nxt;
      s3_d_r   <= s2_d_r;
    end
  end

  // ---------------- S4: fraction of the octave ----------------
  logic signed [19:0] frac_full;
  logic [14:0]        s4_frac_r;
  logic signed [4:0]  s4_oct_r;

  assign frac_full = 20'(s3_d_r) - 20'(s3_oct_r) * 20'sd19200;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_frac_r <= frac_full[14:0];
      s4_oct_r  <= s3_oct_r;
    end
  end

  // ---------------- S5: table index ----------------
  logic [T_W-1:0]    t_val;
  logic [P5_W-1:0]   idx_prod;
  logic [T_W-1:0]    s5_t_r;
  logic [B-1:0]      s5_idx_r;
  logic signed [4:0] s5_oct_r;

  assign t_val    = {s4_frac_r, {B{1'b0}}};
  assign idx_prod = P5_W'(t_val[T_W-1:8]) * P5_W'(RECIP75);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_t_r   <= t_val;
      s5_idx_r <= idx_prod[RECIP_SH+B-1:RECIP_SH];
      s5_oct_r <= s4_oct_r;
    end
  end

  // ---------------- S6: remainder, table read ----------------
  logic [T_W-1:0]    rem_full;
  logic [B:0]        idx1;
  logic [31:0]       e0, e1;
  logic [14:0]       s6_rem_r;
  logic [31:0]       s6_e0_r;
  logic [DIFF_W-1:0] s6_diff_r, s6_diff_nxt;
  logic signed [4:0] s6_oct_r;

  assign rem_full    = s5_t_r - T_W'(s5_idx_r) * T_W'(OCT_UNITS);
  assign idx1        = (B+1)'(s5_idx_r) + (B+1)'(1);
  assign e0          = exp_tab[s5_idx_r];
  assign e1          = exp_tab[idx1];
  assign s6_diff_nxt = DIFF_W'(e1 - e0);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_rem_r  <= rem_full[14:0];
      s6_e0_r   <= e0;
      s6_diff_r <= s6_diff_nxt;
      s6_oct_r  <= s5_oct_r;
    end
  end

  // ---------------- S7: interpolation product ----------------
  logic [42:0]       interp_y;
  logic [Q_W-1:0]    s7_q_r;
  logic [31:0]       s7_e0_r;
  logic signed [4:0] s7_oct_r;

  assign interp_y = 43'(s6_diff_r) * 43'(s6_rem_r) + 43'(HALF_OCT);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_q_r   <= interp_y[Q_W+7:8];
      s7_e0_r  <= s6_e0_r;
      s7_oct_r <= s6_oct_r;
    end
  end

  // ---------------- S8: divide by 75, partial products ----------------
  logic [50:0]       s8_ph_r, s8_pl_r;
  logic [31:0]       s8_e0_r;
  logic signed [4:0] s8_oct_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_ph_r  <= 51'(s7_q_r[Q_W-1:17]) * 51'(RECIP75);
      s8_pl_r  <= 51'(s7_q_r[16:0]) * 51'(RECIP75);
      s8_e0_r  <= s7_e0_r;
      s8_oct_r <= s7_oct_r;
    end
  end

  // ---------------- S9: mantissa ----------------
  logic [67:0]       qsum;
  logic [31:0]       s9_m_r, s9_m_nxt;
  logic signed [4:0] s9_oct_r;

  assign qsum     = {s8_ph_r, 17'd0} + 68'(s8_pl_r);
  assign s9_m_nxt = s8_e0_r + 32'(qsum[67:RECIP_SH]);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_m_r   <= s9_m_nxt;
      s9_oct_r <= s8_oct_r;
    end
  end

  // ---------------- S10: scale by reference ----------------
  logic [55:0] s10_p_r;
  logic [5:0]  s10_sh_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_p_r  <= 56'(ref_freq_r) * 56'(s9_m_r);
      s10_sh_r <= 6'd30 - {s9_oct_r[4], s9_oct_r};
    end
  end

  // ---------------- S11: octave shift, round, saturate ----------------
  logic [56:0] rnd;
  logic [56:0] f_full;
  logic        sat_nxt;
  logic [31:0] s11_freq_r;
  logic        s11_sat_r;

  assign rnd     = 57'(s10_p_r) + (57'd1 << (s10_sh_r - 6'd1));
  assign f_full  = rnd >> s10_sh_r;
  assign sat_nxt = |f_full[56:32];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_freq_r <= sat_nxt ? 32'hFFFF_FFFF : f_full[31:0];
      s11_sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = s11_freq_r;
  assign out_tuser  = s11_sat_r;

endmodule

// ===== rtl/ntf_checker.sv =====
// Port-level assertion checker for the tuned note-to-frequency block, with its bind.
`include "note_to_frequency_tuned_top_defines.svh"

module ntf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  `NTF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")

  `NTF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output item changed")

  `NTF_ASSERT(a_sat_value, out_tvalid && out_tuser |-> out_tdata == 32'hFFFF_FFFF, "saturation flag without full-scale value")

  `NTF_ASSERT(a_ready_when_drained, !out_tvalid || out_tready |-> in_tready, "input stalled while output side moves")

endmodule

bind note_to_frequency_tuned_top ntf_checker u_ntf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the tuned note-to-frequency block.
`timescale 1ns / 1ps

module tb_top;

  localparam int TB          = 6;
  localparam int N_ENT       = (1 << TB) + 1;
  localparam int OCT         = ntf_pkg::OCT_UNITS;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL        = 40;
  localparam int PHASES      = 10;
  localparam int PER_PHASE   = 85;
  localparam int N_DIR       = 22;

  localparam logic [2:0] REG_SPARE = ntf_pkg::REG_OFFS2 + 3'd1;

  typedef struct packed {
    logic [31:0] freq;
    logic        sat;
  } tone_t;

  typedef struct packed {
    logic        known;
    logic [31:0] freq;
    logic        sat;
  } answer_t;

  typedef struct packed {
    logic [2:0]  set;
    logic [6:0]  note;
    logic        known;
    logic [31:0] freq;
    logic        sat;
  } dir_row_t;

  typedef struct packed {
    logic [63:0] ref_freq;
    logic [63:0] ref_note;
    logic [63:0] offs0;
    logic [63:0] offs1;
    logic [63:0] offs2;
  } settings_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [6:0] note_number, [7] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] frequency
  logic        out_tuser;    // [0] saturated
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  note_to_frequency_tuned_top #(.EXP_TABLE_BITS(TB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [23:0] tun_ref_freq;
  logic [6:0]  tun_ref_note;
  logic [51:0] tun_offs [0:2];
  logic [63:0] exp_tab [0:N_ENT-1];

  tone_t   pending_tones [$];
  answer_t table_answers [$];
  int      fails;
  int      send_pct;
  int      recv_pct;
  bit      hold_req;
  int      quiet;

  localparam answer_t NO_ANSWER = '{1'b0, 32'd0, 1'b0};

  localparam settings_t SET_TAB [0:5] = '{
    '{64'd112640, 64'd69, 64'd0, 64'd0, 64'd0},
    '{64'd0, 64'd69, {12'h0, {4{13'h0FFF}}}, {12'h0, {4{13'h0FFF}}},
      {12'h0, {4{13'h0FFF}}}},
    '{64'hFF_FFFF, 64'd0, {12'h0, {4{13'h1000}}}, {12'h0, {4{13'h1000}}},
      {12'h0, {4{13'h1000}}}},
    '{64'd1, 64'd127, {12'h0, {4{13'h0FFF}}}, {12'h0, {4{13'h0FFF}}},
      {12'h0, {4{13'h0FFF}}}},
    '{64'hFF_FFFF, 64'd127, {12'h0, {4{13'h1000}}}, {12'h0, {4{13'h1000}}},
      {12'h0, {4{13'h1000}}}},
    '{64'd112640, 64'd69, {12'h0, 13'h1555, 13'h0AAA, 13'h1000, 13'h0FFF},
      {12'h0, 13'h0001, 13'h1FFF, 13'h0AAA, 13'h1555},
      {12'h0, 13'h0FFF, 13'h1000, 13'h1FFF, 13'h0001}}
  };

  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{3'd0, 7'd69,  1'b1, 32'd112640, 1'b0},
    '{3'd0, 7'd81,  1'b1, 32'd225280, 1'b0},
    '{3'd0, 7'd57,  1'b1, 32'd56320,  1'b0},
    '{3'd0, 7'd0,   1'b0, 32'd0, 1'b0},
    '{3'd0, 7'd127, 1'b0, 32'd0, 1'b0},
    '{3'd0, 7'd60,  1'b0, 32'd0, 1'b0},
    '{3'd1, 7'd0,   1'b1, 32'd0, 1'b0},
    '{3'd1, 7'd127, 1'b1, 32'd0, 1'b0},
    '{3'd1, 7'd70,  1'b1, 32'd0, 1'b0},
    '{3'd2, 7'd127, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{3'd2, 7'd126, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{3'd2, 7'd0,   1'b0, 32'd0, 1'b0},
    '{3'd2, 7'd12,  1'b0, 32'd0, 1'b0},
    '{3'd2, 7'd11,  1'b0, 32'd0, 1'b0},
    '{3'd3, 7'd0,   1'b0, 32'd0, 1'b0},
    '{3'd3, 7'd127, 1'b0, 32'd0, 1'b0},
    '{3'd4, 7'd0,   1'b0, 32'd0, 1'b0},
    '{3'd4, 7'd127, 1'b0, 32'd0, 1'b0},
    '{3'd5, 7'd60,  1'b0, 32'd0, 1'b0},
    '{3'd5, 7'd61,  1'b0, 32'd0, 1'b0},
    '{3'd5, 7'd67,  1'b0, 32'd0, 1'b0},
    '{3'd5, 7'd71,  1'b0, 32'd0, 1'b0}
  };

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  function automatic void fill_exp_table();
    logic [63:0] roots [0:TB];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= TB; k++) roots[k] = sqrt_floor(roots[k-1] << 30);
    for (int i = 0; i < N_ENT; i++) begin
      acc = 64'd1 << 30;
      for (int j = 0; j <= TB; j++) begin
        if (((i >> j) & 1) != 0) acc = (acc * roots[TB-j] + (64'd1 << 29)) >> 30;
      end
      exp_tab[i] = acc;
    end
  endfunction

  function automatic tone_t predict_tone(input logic [6:0] note);
    int          pc;
    int          d;
    int          oct;
    int          frac;
    int          s;
    logic [12:0] raw;
    logic [63:0] t;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] f;
    tone_t       r;
    pc  = int'(note) % 12;
    raw = 13'(tun_offs[pc / 4] >> (13 * (pc % 4)));
    d   = (int'(note) - int'(tun_ref_note)) * ntf_pkg::SEMI_UNITS + int'($signed(raw));
    if (d >= 0) oct = d / OCT;
    else oct = -((-d + OCT - 1) / OCT);
    frac = d - oct * OCT;
    t    = 64'(frac) << TB;
    idx  = t / 64'(OCT);
    rem  = t % 64'(OCT);
    m    = (exp_tab[idx] * (64'(OCT) - rem) + exp_tab[idx + 1] * rem
            + 64'(ntf_pkg::HALF_OCT)) / 64'(OCT);
    p    = 64'(tun_ref_freq) * m;
    s    = 30 - oct;
    f    = (p + (64'd1 << (s - 1))) >> s;
    r.sat  = (f > 64'hFFFF_FFFF);
    r.freq = r.sat ? 32'hFFFF_FFFF : f[31:0];
    return r;
  endfunction

  function automatic void note_write(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      ntf_pkg::REG_REF_FREQ: tun_ref_freq = val[23:0];
      ntf_pkg::REG_REF_NOTE: tun_ref_note = val[6:0];
      ntf_pkg::REG_OFFS0:    tun_offs[0]  = val[51:0];
      ntf_pkg::REG_OFFS1:    tun_offs[1]  = val[51:0];
      ntf_pkg::REG_OFFS2:    tun_offs[2]  = val[51:0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] pick_wide(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [63:0] mid);
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = lo;
      1: v = hi;
      2: v = mid;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.ref_freq = pick_wide(64'hFF_FFFF, 64'd0, 64'd112640);
    s.ref_note = pick_wide(64'd127, 64'd0, 64'd69);
    s.offs0    = pick_wide({12'h0, {4{13'h0FFF}}}, {12'h0, {4{13'h1000}}}, 64'd0);
    s.offs1    = pick_wide({12'h0, {4{13'h0FFF}}}, {12'h0, {4{13'h1000}}}, 64'd0);
    s.offs2    = pick_wide({12'h0, {4{13'h0FFF}}}, {12'h0, {4{13'h1000}}}, 64'd0);
    return s;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    note_write(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic [2:0] idx, input logic [63:0] want, input string name);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== want) begin
      $error("%s: expected %0h, got %0h", name, want, cfg_prdata);
      fails++;
    end
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input settings_t s);
    cfg_write(ntf_pkg::REG_REF_FREQ, s.ref_freq);
    cfg_write(ntf_pkg::REG_REF_NOTE, s.ref_note);
    cfg_write(ntf_pkg::REG_OFFS0, s.offs0);
    cfg_write(ntf_pkg::REG_OFFS1, s.offs1);
    cfg_write(ntf_pkg::REG_OFFS2, s.offs2);
    // unmapped index, must leave everything alone
    cfg_write(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    cfg_check(ntf_pkg::REG_REF_FREQ, 64'(tun_ref_freq), "ref_frequency");
    cfg_check(ntf_pkg::REG_REF_NOTE, 64'(tun_ref_note), "ref_note");
    cfg_check(ntf_pkg::REG_OFFS0, 64'(tun_offs[0]), "offsets_c_to_ds");
    cfg_check(ntf_pkg::REG_OFFS1, 64'(tun_offs[1]), "offsets_e_to_g");
    cfg_check(ntf_pkg::REG_OFFS2, 64'(tun_offs[2]), "offsets_gs_to_b");
  endtask

  task automatic send_note(input logic [6:0] note, input answer_t ans);
    if ($urandom_range(0, 99) < send_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    table_answers.push_back(ans);
    in_tdata  <= {1'b0, note};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tones.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random backpressure, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  always @(posedge clk) begin : monitor
    tone_t   want;
    answer_t ans;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_tones.size() == 0) begin
          $error("result with no pending item: frequency %0d", out_tdata);
          fails++;
        end else begin
          want = pending_tones.pop_front();
          if (out_tdata !== want.freq) begin
            $error("frequency: expected %0d, got %0d", want.freq, out_tdata);
            fails++;
          end
          if (out_tuser !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, out_tuser);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        ans = (table_answers.size() != 0) ? table_answers.pop_front() : NO_ANSWER;
        if (ans.known) pending_tones.push_back('{ans.freq, ans.sat});
        else pending_tones.push_back(predict_tone(in_tdata[6:0]));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL note_to_frequency_tuned_top");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int         cur_set;
    logic [6:0] note;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    fails    = 0;
    quiet    = 0;
    hold_req = 1'b0;
    send_pct = 20;
    recv_pct = 84;
    tun_ref_freq = ntf_pkg::REF_FREQ_RST;
    tun_ref_note = ntf_pkg::REF_NOTE_RST;
    for (int i = 0; i < 3; i++) tun_offs[i] = '0;
    fill_exp_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    for (int r = 0; r < N_DIR; r++) begin
      if (int'(DIR_TAB[r].set) != cur_set) begin
        settle();
        cur_set = int'(DIR_TAB[r].set);
        load_settings(SET_TAB[cur_set]);
      end
      send_note(DIR_TAB[r].note, '{DIR_TAB[r].known, DIR_TAB[r].freq, DIR_TAB[r].sat});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 4) begin
        send_pct = 20;
        recv_pct = 84;
      end else if (ph < 7) begin
        send_pct = 84;
        recv_pct = 20;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      load_settings(random_settings());
      for (int i = 0; i < PER_PHASE; i++) begin
        if (ph == 8 && i == 5) hold_req = 1'b1;
        case ($urandom_range(0, 9))
          0: note = 7'd0;
          1: note = 7'd127;
          2: note = tun_ref_note;
          default: note = 7'($urandom_range(0, 127));
        endcase
        send_note(note, NO_ANSWER);
      end
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (fails == 0) begin
      $display("PASS note_to_frequency_tuned_top");
    end else begin
      $display("FAIL note_to_frequency_tuned_top");
    end
    $finish;
  end

endmodule
